// ----- hw/rtl/cpt_pkg.sv -----
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared widths, register indexes and reset values of the capture-period
// tachometer.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int TOP_W     = 16;
  localparam int NUM_W     = 24;
  localparam int PPR_W     = 4;
  localparam int FRAC_BITS = 8;
  localparam int SPEED_W   = NUM_W + FRAC_BITS;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TIMER_TOP = 2'd0;
  localparam cfg_idx_t CFG_SPEED_NUM = 2'd1;
  localparam cfg_idx_t CFG_PPR       = 2'd2;

  localparam logic [TOP_W-1:0] TOP_RST = 16'hFFFF;
  localparam logic [NUM_W-1:0] NUM_RST = 24'd600000;
  localparam logic [PPR_W-1:0] PPR_RST = 4'd3;

endpackage

// ----- hw/rtl/cpt_cap_if.sv -----
// ----------------------------------------------------------------------------
// cpt_cap_if
// Capture channel: one timer capture value per beat.
// ----------------------------------------------------------------------------
interface cpt_cap_if #(
  parameter int W = 16
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] capture_value;

  modport source (output valid, output capture_value, input ready);
  modport sink   (input valid, input capture_value, output ready);
endinterface

// ----- hw/rtl/cpt_spd_if.sv -----
// ----------------------------------------------------------------------------
// cpt_spd_if
// Speed channel: one speed result per beat.
// ----------------------------------------------------------------------------
interface cpt_spd_if import cpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_q8;
  logic               zero_period;

  modport source (output valid, output speed_q8, output zero_period, input ready);
  modport sink   (input valid, input speed_q8, input zero_period, output ready);
endinterface

// ----- hw/rtl/cpt_ram.sv -----
// ----------------------------------------------------------------------------
// cpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/cpt_serial_div.sv -----
// ----------------------------------------------------------------------------
// cpt_serial_div
// Restoring divider, one quotient bit per cycle. The dividend shifts out of
// the top of a shift register while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module cpt_serial_div #(
  parameter int DVD_W = 32,
  parameter int DVR_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVR_W-1:0] dvr_r, dvr_nxt;
  logic [DVR_W-1:0] rem_r, rem_nxt;
  logic [DVR_W:0]   rem_sh;
  logic [DVR_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvr_r};
  assign ge     = (rem_sh >= {1'b0, dvr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvr_nxt  = dvr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVR_W-1:0] : rem_sh[DVR_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvr_r <= dvr_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ----- hw/rtl/capture_period_tachometer.sv -----
// ----------------------------------------------------------------------------
// capture_period_tachometer
// Averages the period of CAPTURE_DEPTH timer captures and converts it to a
// speed in revolutions per minute with 8 fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   in_cap carries one timer capture per beat. The first CAPTURE_DEPTH beats
//   are stored in a small RAM, one per cycle, with no result. The
//   next beat is dropped and starts the computation; in_cap.ready stays low
//   until it is done.
//   Computation: the RAM is walked and the intervals are summed, a bit-serial
//   division averages them, and a bit-serial division gives the speed; the
//   speed division is skipped when the divisor is zero. The two serial
//   dividers produce one quotient bit per cycle.
//   out_spd holds the result in an output register until it is taken; new
//   captures are still accepted meanwhile, but the following computation
//   waits until the register is empty.
//   cfg_* writes one register per cycle; write only while the block is idle.
//   Reset empties the store, drops any pending result and restores the
//   register defaults.
// ----------------------------------------------------------------------------
module capture_period_tachometer
  import cpt_pkg::*;
#(
  parameter int CAPTURE_DEPTH = 10,
  parameter int TIMER_BITS    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  cpt_cap_if.sink           in_cap,
  cpt_spd_if.source         out_spd,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int AW    = $clog2(CAPTURE_DEPTH);
  localparam int FC_W  = $clog2(CAPTURE_DEPTH + 1);
  localparam int DIV_N = CAPTURE_DEPTH - 1;
  localparam int DN_W  = $clog2(CAPTURE_DEPTH);
  localparam int SUM_W = TIMER_BITS + $clog2(DIV_N);
  localparam int DV_W  = TIMER_BITS + PPR_W;

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_AVG  = 2'd2;
  localparam logic [1:0] ST_SPD  = 2'd3;

  logic [TOP_W-1:0]      timer_top_r;
  logic [NUM_W-1:0]      speed_num_r;
  logic [PPR_W-1:0]      ppr_r;

  logic [1:0]            state_r, state_nxt;
  logic [FC_W-1:0]       fill_cnt_r, fill_cnt_nxt;
  logic [FC_W-1:0]       rd_cnt_r, rd_cnt_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [TIMER_BITS-1:0] prev_r, prev_nxt;
  logic [DV_W-1:0]       dvr_r, dvr_nxt;
  logic                  go_r, go_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0]    speed_r, speed_nxt;
  logic                  zero_r, zero_nxt;

  logic                  full;
  logic                  in_acc;
  logic                  ram_we;
  logic [TIMER_BITS-1:0] rd_data;
  logic [TIMER_BITS-1:0] top_t;
  logic [TIMER_BITS-1:0] intv;
  logic                  avg_start;
  logic                  avg_done;
  logic [SUM_W-1:0]      avg_q;
  logic                  spd_start;
  logic                  spd_done;
  logic [SPEED_W-1:0]    spd_q;
  logic [DV_W-1:0]       product;

  assign full         = (fill_cnt_r == FC_W'(CAPTURE_DEPTH));
  assign in_cap.ready = (state_r == ST_FILL) && !(full && out_valid_r);
  assign in_acc       = in_cap.valid && in_cap.ready;
  assign ram_we       = in_acc && !full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_top_r <= TOP_RST;
      speed_num_r <= NUM_RST;
      ppr_r       <= PPR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TIMER_TOP: timer_top_r <= cfg_wdata[TOP_W-1:0];
        CFG_SPEED_NUM: speed_num_r <= cfg_wdata[NUM_W-1:0];
        CFG_PPR:       ppr_r       <= cfg_wdata[PPR_W-1:0];
        default:       ;
      endcase
    end
  end

  cpt_ram #(
    .WIDTH (TIMER_BITS),
    .DEPTH (CAPTURE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_cnt_r[AW-1:0]),
    .wdata (in_cap.capture_value),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (rd_data)
  );

  // interval between prev_r (earlier) and rd_data (later), modulo timer_top_r + 1
  assign top_t = TIMER_BITS'(timer_top_r);
  assign intv  = (rd_data >= prev_r) ? (rd_data - prev_r)
                                     : (top_t - prev_r + rd_data + 1'b1);

  assign avg_start = go_r && (state_r == ST_AVG);
  assign spd_start = go_r && (state_r == ST_SPD) && (dvr_r != '0);
  assign product   = DV_W'(avg_q[TIMER_BITS-1:0]) * DV_W'(ppr_r);

  cpt_serial_div #(
    .DVD_W (SUM_W),
    .DVR_W (DN_W)
  ) u_avg_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (avg_start),
    .dividend (sum_r),
    .divisor  (DN_W'(DIV_N)),
    .done     (avg_done),
    .quotient (avg_q)
  );

  cpt_serial_div #(
    .DVD_W (SPEED_W),
    .DVR_W (DV_W)
  ) u_spd_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (spd_start),
    .dividend ({speed_num_r, {FRAC_BITS{1'b0}}}),
    .divisor  (dvr_r),
    .done     (spd_done),
    .quotient (spd_q)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_cnt_nxt  = fill_cnt_r;
    rd_cnt_nxt    = rd_cnt_r;
    sum_nxt       = sum_r;
    prev_nxt      = prev_r;
    dvr_nxt       = dvr_r;
    go_nxt        = 1'b0;
    out_valid_nxt = out_valid_r && !out_spd.ready;
    speed_nxt     = speed_r;
    zero_nxt      = zero_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_acc) begin
          if (!full) begin
            fill_cnt_nxt = fill_cnt_r + 1'b1;
          end else begin
            fill_cnt_nxt = '0;
            rd_cnt_nxt   = '0;
            sum_nxt      = '0;
            state_nxt    = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        rd_cnt_nxt = rd_cnt_r + 1'b1;
        if (rd_cnt_r != '0) begin
          prev_nxt = rd_data;
        end
        if (rd_cnt_r >= FC_W'(2)) begin
          sum_nxt = sum_r + SUM_W'(intv);
        end
        if (rd_cnt_r == FC_W'(CAPTURE_DEPTH)) begin
          state_nxt = ST_AVG;
          go_nxt    = 1'b1;
        end
      end
      ST_AVG: begin
        if (avg_done) begin
          dvr_nxt   = product;
          state_nxt = ST_SPD;
          go_nxt    = 1'b1;
        end
      end
      ST_SPD: begin
        if (go_r && dvr_r == '0) begin
          speed_nxt     = '0;
          zero_nxt      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_FILL;
        end else if (spd_done) begin
          speed_nxt     = spd_q;
          zero_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_FILL;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      fill_cnt_r  <= '0;
      rd_cnt_r    <= '0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sum_r   <= sum_nxt;
    prev_r  <= prev_nxt;
    dvr_r   <= dvr_nxt;
    speed_r <= speed_nxt;
    zero_r  <= zero_nxt;
  end

  assign out_spd.valid       = out_valid_r;
  assign out_spd.speed_q8    = speed_r;
  assign out_spd.zero_period = zero_r;

endmodule

// ----- hw/rtl/cpt_chk.sv -----
// ----------------------------------------------------------------------------
// cpt_chk
// Port-level checks on the speed channel of the tachometer.
// ----------------------------------------------------------------------------
module cpt_chk
  import cpt_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SPEED_W-1:0] speed_q8,
  input logic               zero_period
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("speed beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(speed_q8) && $stable(zero_period))
    else $error("speed beat changed while stalled");

  a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_period |-> speed_q8 == '0)
    else $error("zero period with nonzero speed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("speed beat valid after reset");

endmodule

bind capture_period_tachometer cpt_chk u_cpt_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_spd.valid),
  .out_ready   (out_spd.ready),
  .speed_q8    (out_spd.speed_q8),
  .zero_period (out_spd.zero_period)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for capture_period_tachometer. Timer captures go in
// through a directed table and random runs of roughly evenly spaced, equal or
// random captures. Every accepted capture updates an averaging-speed predictor,
// and each speed beat is compared with the oldest prediction. Both channels idle
// at random, and the result side holds off long enough to stall the capture side.
// ----------------------------------------------------------------------------
module tb;
  import cpt_pkg::*;

  localparam int DEPTH       = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 80;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 105;

  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               zero;
  } rpm_t;

  typedef struct packed {
    logic [TOP_W-1:0]   cap;
    logic               pinned;
    logic [SPEED_W-1:0] speed;
    logic               zero;
  } dir_row_t;

  // all-equal store gives a zero period; second set wraps once, 100 ticks apart
  localparam dir_row_t DIRECTED [22] = '{
    '{16'hFFFF, 1'b0, 32'd0, 1'b0}, '{16'hFFFF, 1'b0, 32'd0, 1'b0},
    '{16'hFFFF, 1'b0, 32'd0, 1'b0}, '{16'hFFFF, 1'b0, 32'd0, 1'b0},
    '{16'hFFFF, 1'b0, 32'd0, 1'b0}, '{16'hFFFF, 1'b0, 32'd0, 1'b0},
    '{16'hFFFF, 1'b0, 32'd0, 1'b0}, '{16'hFFFF, 1'b0, 32'd0, 1'b0},
    '{16'hFFFF, 1'b0, 32'd0, 1'b0}, '{16'hFFFF, 1'b0, 32'd0, 1'b0},
    '{16'h0000, 1'b1, 32'd0, 1'b1},
    '{16'd65136, 1'b0, 32'd0, 1'b0}, '{16'd65236, 1'b0, 32'd0, 1'b0},
    '{16'd65336, 1'b0, 32'd0, 1'b0}, '{16'd65436, 1'b0, 32'd0, 1'b0},
    '{16'd0,     1'b0, 32'd0, 1'b0}, '{16'd100,   1'b0, 32'd0, 1'b0},
    '{16'd200,   1'b0, 32'd0, 1'b0}, '{16'd300,   1'b0, 32'd0, 1'b0},
    '{16'd400,   1'b0, 32'd0, 1'b0}, '{16'd500,   1'b0, 32'd0, 1'b0},
    '{16'hFFFF, 1'b1, 32'd512000, 1'b0}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_idx_t         cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  cpt_cap_if #(.W(TOP_W)) cap_ch ();
  cpt_spd_if              spd_ch ();

  capture_period_tachometer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cap    (cap_ch),
    .out_spd   (spd_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [TOP_W-1:0] cap_hist [DEPTH];
  int               cap_fill = 0;
  logic [TOP_W-1:0] top_reg  = TOP_RST;
  logic [NUM_W-1:0] num_reg  = NUM_RST;
  logic [PPR_W-1:0] ppr_reg  = PPR_RST;
  rpm_t             pending_speeds [$];

  rpm_t pin_val;
  bit   pin_on   = 1'b0;
  bit   tx_gaps  = 1'b1;
  bit   rx_gaps  = 1'b1;
  bit   hold_req = 1'b0;

  int err_cnt   = 0;
  int n_caps    = 0;
  int n_results = 0;
  int n_zero    = 0;
  int idle_cyc  = 0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [63:0] ticks_between(logic [TOP_W-1:0] earlier,
                                                 logic [TOP_W-1:0] later);
    if (later >= earlier) return 64'(later) - 64'(earlier);
    return (64'(top_reg) - 64'(earlier) + 64'(later) + 64'd1) & 64'hFFFF;
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [CFG_W-1:0] d);
    case (idx)
      CFG_TIMER_TOP: top_reg = d[TOP_W-1:0];
      CFG_SPEED_NUM: num_reg = d[NUM_W-1:0];
      CFG_PPR:       ppr_reg = d[PPR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void take_capture(logic [TOP_W-1:0] v);
    logic [63:0] sum;
    logic [63:0] div;
    logic [63:0] q;
    rpm_t        e;
    if (cap_fill < DEPTH) begin
      cap_hist[cap_fill] = v;
      cap_fill++;
    end else begin
      sum = 64'd0;
      for (int i = 0; i < DEPTH - 1; i++) sum += ticks_between(cap_hist[i], cap_hist[i+1]);
      div = (sum / 64'(DEPTH - 1)) * 64'(ppr_reg);
      e.speed = '0;
      e.zero  = (div == 64'd0);
      if (div != 64'd0) begin
        q = (64'(num_reg) << FRAC_BITS) / div;
        if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        e.speed = q[SPEED_W-1:0];
      end
      if (pin_on) begin
        e      = pin_val;
        pin_on = 1'b0;
      end
      pending_speeds.push_back(e);
      cap_fill = 0;
    end
  endfunction

  function automatic void check_speed(logic [SPEED_W-1:0] speed, logic zero);
    rpm_t e;
    n_results++;
    if (zero) n_zero++;
    if (pending_speeds.size() == 0) begin
      $error("speed beat with none expected: speed_q8=%0d zero_period=%0b", speed, zero);
      err_cnt++;
    end else begin
      e = pending_speeds.pop_front();
      if (speed !== e.speed) begin
        $error("speed_q8: expected %0d, got %0d", e.speed, speed);
        err_cnt++;
      end
      if (zero !== e.zero) begin
        $error("zero_period: expected %0b, got %0b", e.zero, zero);
        err_cnt++;
      end
    end
  endfunction

  // monitor: register writes, accepted beats, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) apply_reg(cfg_addr, cfg_wdata);
      if (cap_ch.valid && cap_ch.ready) begin
        take_capture(cap_ch.capture_value);
        n_caps++;
      end
      if (spd_ch.valid && spd_ch.ready) check_speed(spd_ch.speed_q8, spd_ch.zero_period);
      if ((cap_ch.valid && cap_ch.ready) || (spd_ch.valid && spd_ch.ready)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= STALL_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_speeds.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    int g;
    logic nxt;
    stall_left = 0;
    hold_left  = 0;
    spd_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      nxt = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (hold_req) begin
        hold_left = HOLD_CYCLES - 1;
        hold_req  = 1'b0;
        nxt       = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else if (rx_gaps) begin
        g = rand_gap();
        if (g > 0) begin
          stall_left = g - 1;
          nxt        = 1'b0;
        end
      end
      spd_ch.ready <= nxt;
    end
  end

  task automatic send_capture(input logic [TOP_W-1:0] v);
    int g;
    g = tx_gaps ? rand_gap() : 0;
    if (g > 0) begin
      cap_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    cap_ch.valid         <= 1'b1;
    cap_ch.capture_value <= v;
    do @(posedge clk); while (!(cap_ch.valid && cap_ch.ready));
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= d;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [TOP_W-1:0] top, input logic [NUM_W-1:0] num,
                          input logic [PPR_W-1:0] ppr, input logic [CFG_W-1:0] junk);
    write_reg(CFG_TIMER_TOP, {junk[CFG_W-1:TOP_W], top});
    write_reg(CFG_SPEED_NUM, num);
    write_reg(CFG_PPR, {junk[CFG_W-1:PPR_W], ppr});
    write_reg(CFG_UNUSED, junk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    cap_ch.valid <= 1'b0;
    while (pending_speeds.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int sent;
    int kind;
    int span;
    int base;
    int v;
    int r;
    int n_settings;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_addr             = CFG_TIMER_TOP;
    cfg_wdata            = '0;
    cap_ch.valid         = 1'b0;
    cap_ch.capture_value = '0;
    n_settings           = 1;
    for (int i = 0; i < DEPTH; i++) cap_hist[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].pinned) begin
        pin_val.speed = DIRECTED[i].speed;
        pin_val.zero  = DIRECTED[i].zero;
        pin_on        = 1'b1;
      end
      send_capture(DIRECTED[i].cap);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      case (p)
        1: set_regs(16'hFFFF, 24'hFFFFFF, 4'hF, 24'hFFFFFF);
        2: set_regs(16'd1, 24'd1, 4'd1, CFG_W'($urandom));
        3: set_regs(16'd0, 24'd0, 4'd0, 24'd0);
        4: set_regs(16'd1000, 24'd600000, 4'd1, CFG_W'($urandom));
        5, 6: set_regs(TOP_W'($urandom_range(1, 65535)),
                       NUM_W'($urandom_range(1, 24'hFFFFFF)),
                       PPR_W'($urandom_range(1, 15)), CFG_W'($urandom));
        7: set_regs(TOP_RST, NUM_RST, PPR_RST, CFG_W'($urandom));
        default: ;
      endcase
      if (p > 0) n_settings++;
      tx_gaps = (p != 1) && (p != 4);
      rx_gaps = (p != 4) && (p != 6);
      if (p == 1) hold_req = 1'b1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        span = int'(top_reg) + 1;
        kind = $urandom_range(0, 99);
        if (kind < 72) begin
          r = $urandom_range(0, 2);
          if (r == 0) base = $urandom_range(0, 20);
          else if (r == 1) base = $urandom_range(20, 3000);
          else base = $urandom_range(0, span - 1);
          v = $urandom_range(0, span - 1);
          repeat (DEPTH + 1) begin
            send_capture(v[TOP_W-1:0]);
            v = (v + base + $urandom_range(0, base / 4)) % span;
          end
          sent += DEPTH + 1;
        end else if (kind < 82) begin
          v = $urandom_range(0, 65535);
          repeat (DEPTH + 1) send_capture(v[TOP_W-1:0]);
          sent += DEPTH + 1;
        end else begin
          r = $urandom_range(1, 15);
          repeat (r) send_capture(TOP_W'($urandom_range(0, 65535)));
          sent += r;
        end
      end
    end
    settle();

    if (pending_speeds.size() != 0) begin
      $error("%0d speed results never arrived", pending_speeds.size());
      err_cnt++;
    end
    $display("Run covered %0d captures and %0d speed beats (%0d with zero period)",
             n_caps, n_results, n_zero);
    $display("across %0d register settings, with random stalls and one long hold-off.",
             n_settings);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
